>>> src/tevq_pkg.sv
// shared types, constants and helpers of the timed event release queue
`default_nettype none

package tevq_pkg;

    // ring buffer geometry: one slot is always kept free
    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH);
    localparam int MAX_RELEASE = 10;

    // field widths
    localparam int TIME_W    = 48;
    localparam int PAYLOAD_W = 32;
    localparam int ENTRY_W   = TIME_W + PAYLOAD_W;
    localparam int LEVEL_W   = 6;
    localparam int COUNT_W   = 32;
    localparam int LIMIT_W   = 4;
    localparam int S_DATA_W  = 128;
    localparam int M_DATA_W  = 112;

    localparam logic [FILL_W-1:0]  FILL_MAX   = FILL_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX  = LIMIT_W'(MAX_RELEASE);
    localparam logic [LIMIT_W-1:0] LIMIT_INIT = LIMIT_W'(MAX_RELEASE);

    typedef enum logic {
        OP_SCHEDULE = 1'b0,
        OP_POLL     = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_CTRL     = 2'd2,
        KIND_STEP     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_ACCEPTED   = 2'd0,
        STAT_DROPPED    = 2'd1,
        STAT_RELEASED   = 2'd2,
        STAT_NOTHING_DUE = 2'd3
    } status_t;

    // one result item as held in the output and pending registers
    typedef struct packed {
        status_t             status;
        logic [1:0]          kind;
        logic [3:0]          channel;
        logic [6:0]          data_first;
        logic [6:0]          data_second;
        logic [3:0]          track;
        logic [7:0]          step;
        logic                last;
        logic [LEVEL_W-1:0]  level;
        logic [LEVEL_W-1:0]  peak;
        logic [COUNT_W-1:0]  dropped;
        logic [COUNT_W-1:0]  released;
    } result_t;

    // queue fill count shown as a 6 bit level
    function automatic logic [LEVEL_W-1:0] to_level(input logic [FILL_W-1:0] f);
        logic [FILL_W+LEVEL_W-1:0] w;
        w = {{LEVEL_W{1'b0}}, f};
        return w[LEVEL_W-1:0];
    endfunction

    // zero acts as one, anything above ten acts as ten
    function automatic logic [LIMIT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] v);
        logic [LIMIT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = LIMIT_W'(1);
        end else if (v > LIMIT_MAX) begin
            r = LIMIT_MAX;
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> src/tevq_ram.sv
// generic simple dual port ram, one write port and one registered read port
`default_nettype none

module tevq_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> src/timed_event_release_queue.sv
// top level of the timed event release queue
`default_nettype none

// In-order release queue for timestamped note, controller and sequencer step
// events. A schedule item (tuser 0) appends one event to a 64-slot ring buffer
// holding at most 63 entries; when full the event is dropped, counted, and one
// result with status dropped comes back. A poll item (tuser 1) carries the
// current time and releases events from the head while the head entry is due
// (due time <= now), the queue is not empty and fewer than release_limit events
// went out for this poll; the last released event carries tlast, and a poll
// that releases nothing gives a single nothing-due result with tlast set.
// Every result also reports queue level, peak level and the wrapping drop and
// release counters. One item is worked on at a time: a schedule passes through
// the schedule state, and a poll passes through an issue state and a compare state
// for each head entry, as the event ram has a single registered read port; both
// wait while the result side holds tready low. The output register lets the next
// item be accepted while the previous result still waits to be taken.
// release_limit resets to 10; 0 acts as 1 and values above 10 act as 10.

module timed_event_release_queue
    import tevq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // release limit register
    input  wire logic                 cfg_wr_en,
    input  wire logic [LIMIT_W-1:0]   cfg_wr_data,

    // input items
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // event_kind, channel, data_first, data_second, track, step_index,
    // due_time, now_time
    input  wire logic [S_DATA_W-1:0]  s_axis_tdata,
    // op
    input  wire logic [0:0]           s_axis_tuser,

    // result items
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // out_kind, out_channel, out_data_first, out_data_second, out_track,
    // out_step, queue_level, peak_level, dropped_total, released_total, zero fill
    output logic [M_DATA_W-1:0]       m_axis_tdata,
    // status
    output logic [1:0]                m_axis_tuser,
    output logic                      m_axis_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCHED,
        ST_ISSUE,
        ST_CMP
    } state_t;

    state_t              state_reg, state_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   peak_reg, peak_next;
    logic [COUNT_W-1:0]  drop_reg, drop_next;
    logic [COUNT_W-1:0]  rel_reg, rel_next;
    logic [LIMIT_W-1:0]  sent_reg, sent_next;      // events released by this poll
    logic [S_DATA_W-1:0] in_reg, in_next;         // captured input item
    result_t             pend_reg, pend_next;     // released event waiting for its last bit
    logic                pend_valid_reg, pend_valid_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    // input item fields
    logic [1:0]          in_kind;
    logic [3:0]          in_channel;
    logic [6:0]          in_data_first;
    logic [6:0]          in_data_second;
    logic [3:0]          in_track;
    logic [7:0]          in_step;
    logic [TIME_W-1:0]   in_due;
    logic [TIME_W-1:0]   in_now;
    logic [PAYLOAD_W-1:0] in_payload;

    // ram
    logic                ram_wr_en;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic [ENTRY_W-1:0]  ram_rd_data;
    logic [TIME_W-1:0]   head_due;
    logic [PAYLOAD_W-1:0] head_payload;

    logic                in_fire;
    logic                out_free;
    logic                can_release;
    logic                s_op;

    assign in_kind        = in_reg[1:0];
    assign in_channel     = in_reg[5:2];
    assign in_data_first  = in_reg[12:6];
    assign in_data_second = (in_reg[1:0] == KIND_NOTE_OFF) ? 7'd0 : in_reg[19:13];
    assign in_track       = in_reg[23:20];
    assign in_step        = in_reg[31:24];
    assign in_due         = in_reg[79:32];
    assign in_now         = in_reg[127:80];
    assign in_payload     = {in_kind, in_channel, in_data_first, in_data_second,
                             in_track, in_step};

    assign ram_wr_data  = {in_due, in_payload};
    assign head_due     = ram_rd_data[ENTRY_W-1:PAYLOAD_W];
    assign head_payload = ram_rd_data[PAYLOAD_W-1:0];

    // event store, read address always follows the head
    tevq_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_event_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (ram_wr_data),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    assign s_op          = s_axis_tuser[0];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // head entry can go out: queue not empty, under the limit, and due
    assign can_release = (fill_reg != '0) && (sent_reg < clamp_limit(limit_reg))
                         && (head_due <= in_now);

    always_comb begin
        state_next      = state_reg;
        limit_next      = cfg_wr_en ? cfg_wr_data : limit_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        peak_next       = peak_reg;
        drop_next       = drop_reg;
        rel_next        = rel_reg;
        sent_next       = sent_reg;
        in_next         = in_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        ram_wr_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    in_next   = s_axis_tdata;
                    sent_next = '0;
                    state_next = (s_op == OP_POLL) ? ST_ISSUE : ST_SCHED;
                end
            end

            ST_SCHED: begin
                if (out_free) begin
                    out_next        = '0;
                    out_next.last   = 1'b1;
                    out_next.released = rel_reg;
                    out_valid_next  = 1'b1;
                    if (fill_reg >= FILL_MAX) begin
                        drop_next          = drop_reg + COUNT_W'(1);
                        out_next.status    = STAT_DROPPED;
                        out_next.level     = to_level(fill_reg);
                        out_next.peak      = to_level(peak_reg);
                        out_next.dropped   = drop_next;
                    end else begin
                        ram_wr_en  = 1'b1;
                        tail_next  = next_slot(tail_reg);
                        fill_next  = fill_reg + FILL_W'(1);
                        peak_next  = (fill_next > peak_reg) ? fill_next : peak_reg;
                        out_next.status  = STAT_ACCEPTED;
                        out_next.level   = to_level(fill_next);
                        out_next.peak    = to_level(peak_next);
                        out_next.dropped = drop_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            // ram read of the head entry is in flight
            ST_ISSUE: begin
                state_next = ST_CMP;
            end

            ST_CMP: begin
                // a result goes out when the held release is resolved or nothing is due
                if (out_free || (!pend_valid_reg && can_release)) begin
                    if (pend_valid_reg) begin
                        out_next       = pend_reg;
                        out_next.last  = !can_release;
                        out_valid_next = 1'b1;
                    end else if (!can_release) begin
                        out_next          = '0;
                        out_next.status   = STAT_NOTHING_DUE;
                        out_next.last     = 1'b1;
                        out_next.level    = to_level(fill_reg);
                        out_next.peak     = to_level(peak_reg);
                        out_next.dropped  = drop_reg;
                        out_next.released = rel_reg;
                        out_valid_next    = 1'b1;
                    end

                    if (can_release) begin
                        head_next = next_slot(head_reg);
                        fill_next = fill_reg - FILL_W'(1);
                        rel_next  = rel_reg + COUNT_W'(1);
                        sent_next = sent_reg + LIMIT_W'(1);
                        pend_next.status      = STAT_RELEASED;
                        pend_next.kind        = head_payload[31:30];
                        pend_next.channel     = head_payload[29:26];
                        pend_next.data_first  = head_payload[25:19];
                        pend_next.data_second = head_payload[18:12];
                        pend_next.track       = head_payload[11:8];
                        pend_next.step        = head_payload[7:0];
                        pend_next.last        = 1'b0;
                        pend_next.level       = to_level(fill_next);
                        pend_next.peak        = to_level(peak_reg);
                        pend_next.dropped     = drop_reg;
                        pend_next.released    = rel_next;
                        pend_valid_next       = 1'b1;
                        state_next            = ST_ISSUE;
                    end else begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            limit_reg      <= LIMIT_INIT;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            peak_reg       <= '0;
            drop_reg       <= '0;
            rel_reg        <= '0;
            sent_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            limit_reg      <= limit_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            peak_reg       <= peak_next;
            drop_reg       <= drop_next;
            rel_reg        <= rel_next;
            sent_reg       <= sent_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        // payload, no reset needed
        in_reg   <= in_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // result port
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {4'b0000, out_reg.released, out_reg.dropped, out_reg.peak,
                            out_reg.level, out_reg.step, out_reg.track,
                            out_reg.data_second, out_reg.data_first,
                            out_reg.channel, out_reg.kind};

    // no release left unresolved once the block takes a new item
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !pend_valid_reg)
        else $error("pending release left over at idle");

    // peak never below the current fill
    assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= fill_reg)
        else $error("peak level below queue level");

    // fill moves only on a schedule or a release
    assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (fill_reg != $past(fill_reg)) |->
            ($past(state_reg) == ST_SCHED || $past(state_reg) == ST_CMP))
        else $error("queue level changed outside schedule or release");

endmodule

`default_nettype wire
